### design/block_run_fragmenter_assert.svh
// Assertion macros shared by the block run fragmenter modules.
`ifndef BLOCK_RUN_FRAGMENTER_ASSERT_SVH
`define BLOCK_RUN_FRAGMENTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("block run fragmenter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("block run fragmenter: next-cycle check failed");

`endif

### design/brf_pkg.sv
// Shared widths, register codes and structs of the block run fragmenter.
package brf_pkg;

    localparam int OFFSET_BITS   = 48;
    localparam int OUT_BITS      = 48;
    localparam int BSIZE_BITS    = 17;
    localparam int GAP_BITS      = 16;
    localparam int MINF_BITS     = 16;
    localparam int MAXF_BITS     = 20;
    localparam int IDX_BITS      = 32;
    localparam int GCNT_BITS     = 17;
    localparam int MINB_BITS     = MINF_BITS + BSIZE_BITS;
    localparam int PROD_BITS     = BSIZE_BITS + IDX_BITS;
    localparam int CMP_BITS      = 64;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BSIZE_BITS-1:0] BSIZE_RESET = BSIZE_BITS'(512);
    localparam logic [GAP_BITS-1:0]   GAP_RESET   = '0;
    localparam logic [MINF_BITS-1:0]  MINF_RESET  = '0;
    localparam logic [MAXF_BITS-1:0]  MAXF_RESET  = '1;
    localparam logic [OUT_BITS-1:0]   BASE_RESET  = '0;

    typedef logic [OFFSET_BITS-1:0] t_addr;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BLOCK_SIZE  = 8'd0,
        REG_GAP_BLOCKS  = 8'd1,
        REG_MIN_FRAG    = 8'd2,
        REG_MAX_FRAG    = 8'd3,
        REG_BASE_OFFSET = 8'd4
    } t_cfg_reg;

    // Configuration as seen by the core
    typedef struct packed {
        logic [BSIZE_BITS-1:0] block_size;
        logic [GAP_BITS-1:0]   gap_blocks;
        logic [MINB_BITS-1:0]  min_bytes;
        logic [MAXF_BITS-1:0]  max_fragments;
        logic [OUT_BITS-1:0]   base_offset;
        logic                  bs_changed;
    } t_cfg;

    // One fragment result
    typedef struct packed {
        logic [OUT_BITS-1:0] offset;
        logic [OUT_BITS-1:0] size;
        logic                is_header;
        logic                last;
    } t_frag;

    // Up to two results written per processed item, first one first
    typedef struct packed {
        logic  first_valid;
        t_frag first;
        logic  second_valid;
        t_frag second;
    } t_push;

endpackage

### design/brf_cfg.sv
// Configuration registers and the derived minimum fragment size in bytes.
module brf_cfg
    import brf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    logic [BSIZE_BITS-1:0] r_block_size;
    logic [GAP_BITS-1:0]   r_gap_blocks;
    logic [MINF_BITS-1:0]  r_min_frag;
    logic [MAXF_BITS-1:0]  r_max_frag;
    logic [OUT_BITS-1:0]   r_base_offset;
    logic [MINB_BITS-1:0]  r_min_bytes;
    logic                  r_bs_changed;
    logic                  w_wr;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;

    // Write registers; flag a block size change for the position rebuild
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= BSIZE_RESET;
            r_gap_blocks  <= GAP_RESET;
            r_min_frag    <= MINF_RESET;
            r_max_frag    <= MAXF_RESET;
            r_base_offset <= BASE_RESET;
            r_min_bytes   <= '0;
            r_bs_changed  <= 1'b0;
        end else begin
            r_bs_changed <= 1'b0;
            r_min_bytes  <= MINB_BITS'(r_min_frag) * MINB_BITS'(r_block_size);
            if (w_wr) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_BLOCK_SIZE: begin
                        r_block_size <= i_cfg_data[BSIZE_BITS-1:0];
                        r_bs_changed <= 1'b1;
                    end
                    REG_GAP_BLOCKS:  r_gap_blocks  <= i_cfg_data[GAP_BITS-1:0];
                    REG_MIN_FRAG:    r_min_frag    <= i_cfg_data[MINF_BITS-1:0];
                    REG_MAX_FRAG:    r_max_frag    <= i_cfg_data[MAXF_BITS-1:0];
                    REG_BASE_OFFSET: r_base_offset <= i_cfg_data[OUT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg.block_size    = r_block_size;
    assign o_cfg.gap_blocks    = r_gap_blocks;
    assign o_cfg.min_bytes     = r_min_bytes;
    assign o_cfg.max_fragments = r_max_frag;
    assign o_cfg.base_offset   = r_base_offset;
    assign o_cfg.bs_changed    = r_bs_changed;

endmodule

### design/brf_queue.sv
// Result queue: takes up to two fragments a cycle, hands out one beat a cycle unless stalled.
module brf_queue
    import brf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_stall,
    output t_frag o_frag
);

`include "block_run_fragmenter_assert.svh"

    t_frag                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] w_npush;
    logic [QPTR_BITS-1:0] w_second_ptr;
    logic                 w_pop;

    assign w_npush      = QCNT_BITS'(i_push.first_valid) + QCNT_BITS'(i_push.second_valid);
    assign w_second_ptr = r_wr_ptr + QPTR_BITS'(i_push.first_valid);
    assign w_pop        = o_valid && !i_stall;

    // Room for a full pair of results, judged on the registered fill
    assign o_room  = r_count <= QCNT_BITS'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_frag  = r_mem[r_rd_ptr];

    // Store results in order
    always_ff @(posedge i_clk) begin
        if (i_push.first_valid) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.second_valid) begin
            r_mem[w_second_ptr] <= i_push.second;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_BITS'(w_npush);
            r_rd_ptr <= r_rd_ptr + QPTR_BITS'(w_pop);
            r_count  <= r_count + w_npush - QCNT_BITS'(w_pop);
        end
    end

    `BRF_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= QCNT_BITS'(QUEUE_DEPTH))
    `BRF_ASSERT_NOW(a_push_fits, w_npush != '0, ({1'b0, r_count} + {1'b0, w_npush}) <= (QCNT_BITS + 1)'(QUEUE_DEPTH))
    `BRF_ASSERT_NEXT(a_count_tracks, 1'b1, r_count == ($past(r_count) + $past(w_npush) - QCNT_BITS'($past(w_pop))))

endmodule

### design/brf_core.sv
// Input register and single-pass fragment state update.
module brf_core
    import brf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  i_block_used,
    input  logic  i_block_header,
    input  logic  i_end_of_image,
    input  t_cfg  i_cfg,
    input  logic  i_room,
    output t_push o_push
);

`include "block_run_fragmenter_assert.svh"

    // Input register
    logic r_in_valid;
    logic r_used;
    logic r_hdr;
    logic r_end;

    // Running state
    logic [IDX_BITS-1:0]  r_block_index, n_block_index;
    logic [GCNT_BITS-1:0] r_gap_count,   n_gap_count;
    t_addr                r_open_start,  n_open_start;
    t_addr                r_open_length, n_open_length;
    logic                 r_open_header, n_open_header;
    logic                 r_open_flag,   n_open_flag;
    logic [MAXF_BITS-1:0] r_emitted,     n_emitted;
    logic                 r_stopped,     n_stopped;
    t_addr                r_pos,         n_pos;

    logic                 w_take;
    logic                 w_proc;
    logic                 w_halt;
    logic                 w_gap_ok;
    logic                 w_full;
    logic                 w_drop;
    t_addr                w_bsize;
    logic [PROD_BITS-1:0] w_pos_prod;

    assign w_proc     = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !w_proc;
    assign w_take     = i_in_valid && !o_in_stall;

    assign w_bsize    = t_addr'(i_cfg.block_size);
    assign w_pos_prod = PROD_BITS'(i_cfg.block_size) * PROD_BITS'(r_block_index);
    assign w_gap_ok   = r_gap_count <= GCNT_BITS'(i_cfg.gap_blocks);
    assign w_full     = r_emitted >= i_cfg.max_fragments;
    assign w_drop     = !r_open_header &&
                        (CMP_BITS'(r_open_length) <= CMP_BITS'(i_cfg.min_bytes));

    // Hold the beat until the result queue has room for two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_take || (r_in_valid && !w_proc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_used <= i_block_used;
            r_hdr  <= i_block_header;
            r_end  <= i_end_of_image;
        end
    end

    // Process a block, then any end-of-image flush on the new state; else rebuild
    always_comb begin
        n_block_index = r_block_index;
        n_gap_count   = r_gap_count;
        n_open_start  = r_open_start;
        n_open_length = r_open_length;
        n_open_header = r_open_header;
        n_open_flag   = r_open_flag;
        n_emitted     = r_emitted;
        n_stopped     = r_stopped;
        n_pos         = r_pos;
        w_halt        = 1'b0;
        o_push        = '0;

        o_push.first.offset    = OUT_BITS'(r_open_start + t_addr'(i_cfg.base_offset));
        o_push.first.size      = OUT_BITS'(r_open_length);
        o_push.first.is_header = r_open_header;

        if (w_proc) begin
            if (!r_stopped) begin
                if (r_used) begin
                    if (r_hdr) begin
                        // Header closes the open fragment and opens its own
                        if (r_open_flag) begin
                            if (w_full) begin
                                w_halt = 1'b1;
                            end else if (!w_drop) begin
                                o_push.first_valid = 1'b1;
                                n_emitted = r_emitted + 1'b1;
                            end
                        end
                        if (!w_halt) begin
                            n_open_start  = r_pos;
                            n_open_length = w_bsize;
                            n_open_header = 1'b1;
                        end
                    end else if (r_open_flag) begin
                        // Extend unless the gap already overran
                        if (w_gap_ok) begin
                            n_open_length = r_pos + w_bsize - r_open_start;
                        end
                    end else begin
                        n_open_start  = r_pos;
                        n_open_length = w_bsize;
                        n_open_header = 1'b0;
                    end
                    if (!w_halt) begin
                        n_gap_count = '0;
                        n_open_flag = 1'b1;
                    end
                end else begin
                    // Unused block: close on gap overrun, else count the gap
                    if (!w_gap_ok) begin
                        if (w_full) begin
                            w_halt = 1'b1;
                        end else begin
                            if (!w_drop) begin
                                o_push.first_valid = 1'b1;
                                n_emitted = r_emitted + 1'b1;
                            end
                            n_gap_count = '0;
                            n_open_flag = 1'b0;
                        end
                    end else if (r_open_flag) begin
                        n_gap_count = r_gap_count + 1'b1;
                    end
                end
                if (w_halt) begin
                    n_stopped = 1'b1;
                end else begin
                    n_block_index = r_block_index + 1'b1;
                    n_pos = (&r_block_index) ? '0 : r_pos + w_bsize;
                end
            end

            if (r_end) begin
                // Flush the open fragment, then clear everything
                o_push.second.offset    = OUT_BITS'(n_open_start + t_addr'(i_cfg.base_offset));
                o_push.second.size      = OUT_BITS'(n_open_length);
                o_push.second.is_header = n_open_header;
                if (!n_stopped && n_open_flag && (n_open_length != '0) &&
                    (n_emitted < i_cfg.max_fragments) &&
                    (n_open_header ||
                     (CMP_BITS'(n_open_length) > CMP_BITS'(i_cfg.min_bytes)))) begin
                    o_push.second_valid = 1'b1;
                end
                n_block_index = '0;
                n_gap_count   = '0;
                n_open_start  = '0;
                n_open_length = '0;
                n_open_header = 1'b0;
                n_open_flag   = 1'b0;
                n_emitted     = '0;
                n_stopped     = 1'b0;
                n_pos         = '0;
            end
        end else if (i_cfg.bs_changed) begin
            // Rebuild the byte position after a block size change
            n_pos = t_addr'(w_pos_prod);
        end

        o_push.first.last  = !o_push.second_valid;
        o_push.second.last = 1'b1;
    end

    // Update state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_index <= '0;
            r_gap_count   <= '0;
            r_open_start  <= '0;
            r_open_length <= '0;
            r_open_header <= 1'b0;
            r_open_flag   <= 1'b0;
            r_emitted     <= '0;
            r_stopped     <= 1'b0;
            r_pos         <= '0;
        end else begin
            r_block_index <= n_block_index;
            r_gap_count   <= n_gap_count;
            r_open_start  <= n_open_start;
            r_open_length <= n_open_length;
            r_open_header <= n_open_header;
            r_open_flag   <= n_open_flag;
            r_emitted     <= n_emitted;
            r_stopped     <= n_stopped;
            r_pos         <= n_pos;
        end
    end

    `BRF_ASSERT_NEXT(a_end_clears, w_proc && r_end, (r_block_index == '0) && !r_open_flag && !r_stopped && (r_emitted == '0))

endmodule

### design/block_run_fragmenter.sv
// A beat waits in the input register until the queue has room; then its results enter the queue.
// Throughput: one block beat per cycle while each block yields at most one result and the
// output side takes one beat per cycle; a block that yields two results raises the queue fill
// by one, and a held beat stalls intake while three or more results wait in the queue.
// Reset: synchronous, active low; clears fragment state and loads register defaults at once.
module block_run_fragmenter
    import brf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_block_used,
    input  logic                     i_block_header,
    input  logic                     i_end_of_image,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [OUT_BITS-1:0]      o_frag_offset,
    output logic [OUT_BITS-1:0]      o_frag_size,
    output logic                     o_frag_is_header,
    output logic                     o_last_of_run,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg  w_cfg;
    t_push w_push;
    t_frag w_frag;
    logic  w_room;

    brf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    brf_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_block_used   (i_block_used),
        .i_block_header (i_block_header),
        .i_end_of_image (i_end_of_image),
        .i_cfg          (w_cfg),
        .i_room         (w_room),
        .o_push         (w_push)
    );

    brf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_frag  (w_frag)
    );

    assign o_frag_offset    = w_frag.offset;
    assign o_frag_size      = w_frag.size;
    assign o_frag_is_header = w_frag.is_header;
    assign o_last_of_run    = w_frag.last;

endmodule

### tb/tb.sv
// Self-checking testbench for the block run fragmenter: scoreboard prediction, random idle.
module tb;
    import brf_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 90;
    localparam int NUM_PHASES     = 9;

    localparam logic [CFG_DATA_BITS-1:0] MAXF_ALL = CFG_DATA_BITS'(MAXF_RESET);
    localparam logic [CFG_DATA_BITS-1:0] BASE_TOP = {OUT_BITS{1'b1}};

    // Predicts the fragments the block emits and holds them until they arrive
    class frag_scoreboard;
        t_frag                  expected_q[$];
        int                     errors;
        logic [BSIZE_BITS-1:0]  blk_size;
        logic [GAP_BITS-1:0]    gap_lim;
        logic [MINF_BITS-1:0]   min_blocks;
        logic [MAXF_BITS-1:0]   max_frags;
        logic [OUT_BITS-1:0]    base;
        logic [IDX_BITS-1:0]    blk_idx;
        logic [GCNT_BITS-1:0]   gap_cnt;
        logic [OFFSET_BITS-1:0] run_start;
        logic [OFFSET_BITS-1:0] run_len;
        logic [MAXF_BITS-1:0]   emitted;
        bit                     run_hdr;
        bit                     run_open;
        bit                     halted;

        function void clear_run();
            blk_idx   = '0;
            gap_cnt   = '0;
            run_start = '0;
            run_len   = '0;
            run_hdr   = 1'b0;
            run_open  = 1'b0;
            emitted   = '0;
            halted    = 1'b0;
        endfunction

        function void reset_all();
            blk_size   = BSIZE_RESET;
            gap_lim    = GAP_RESET;
            min_blocks = MINF_RESET;
            max_frags  = MAXF_RESET;
            base       = BASE_RESET;
            errors     = 0;
            expected_q.delete();
            clear_run();
        endfunction

        function void write_reg(t_cfg_reg r, logic [CFG_DATA_BITS-1:0] d);
            case (r)
                REG_BLOCK_SIZE:  blk_size   = d[BSIZE_BITS-1:0];
                REG_GAP_BLOCKS:  gap_lim    = d[GAP_BITS-1:0];
                REG_MIN_FRAG:    min_blocks = d[MINF_BITS-1:0];
                REG_MAX_FRAG:    max_frags  = d[MAXF_BITS-1:0];
                REG_BASE_OFFSET: base       = d[OUT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Close out the open run; return 1 when the fragment limit blocks it
        function bit try_emit();
            t_frag f;
            if (emitted >= max_frags)
                return 1'b1;
            // drop short runs that do not start with a header
            if (!run_hdr && 64'(run_len) <= 64'(min_blocks) * 64'(blk_size))
                return 1'b0;
            f.offset    = run_start + base;
            f.size      = run_len;
            f.is_header = run_hdr;
            f.last      = 1'b0;
            expected_q.push_back(f);
            emitted = emitted + 1'b1;
            return 1'b0;
        endfunction

        function void open_run(bit hdr);
            run_start = OFFSET_BITS'(64'(blk_size) * 64'(blk_idx));
            run_len   = OFFSET_BITS'(blk_size);
            run_hdr   = hdr;
        endfunction

        function void advance(bit used, bit hdr);
            if (used) begin
                if (hdr) begin
                    // a header closes the open run; a full limit stops everything
                    if (run_open && try_emit()) begin
                        halted = 1'b1;
                        return;
                    end
                    open_run(1'b1);
                end else if (run_open) begin
                    // extend only while the gap is still bridged
                    if (gap_cnt <= gap_lim)
                        run_len = OFFSET_BITS'(64'(blk_size) * (64'(blk_idx) + 64'd1)
                                               - 64'(run_start));
                end else begin
                    open_run(1'b0);
                end
                gap_cnt  = '0;
                run_open = 1'b1;
            end else if (gap_cnt > gap_lim) begin
                if (try_emit()) begin
                    halted = 1'b1;
                    return;
                end
                gap_cnt  = '0;
                run_open = 1'b0;
            end else if (run_open) begin
                gap_cnt = gap_cnt + 1'b1;
            end
            blk_idx = blk_idx + 1'b1;
        endfunction

        // Note one accepted block beat and queue the fragments it causes
        function void note_block(bit used, bit hdr, bit eoi);
            int n0;
            n0 = expected_q.size();
            if (!halted)
                advance(used, hdr);
            if (eoi) begin
                if (!halted && run_open && run_len != '0)
                    void'(try_emit());
                clear_run();
            end
            if (expected_q.size() > n0)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void cmp_field(string name, logic [OUT_BITS-1:0] want,
                                logic [OUT_BITS-1:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        // Check one accepted fragment beat against the oldest prediction
        function void check_frag(t_frag got);
            t_frag want;
            if (expected_q.size() == 0) begin
                $error("unexpected fragment: offset %h size %h", got.offset, got.size);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            cmp_field("frag_offset", want.offset, got.offset);
            cmp_field("frag_size", want.size, got.size);
            cmp_field("frag_is_header", want.is_header, got.is_header);
            cmp_field("last_of_run", want.last, got.last);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_block_used;
    logic                     i_block_header;
    logic                     i_end_of_image;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [OUT_BITS-1:0]      o_frag_offset;
    logic [OUT_BITS-1:0]      o_frag_size;
    logic                     o_frag_is_header;
    logic                     o_last_of_run;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    bit             quiet;
    bit             hold_req;
    frag_scoreboard sb;

    block_run_fragmenter i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_block_used     (i_block_used),
        .i_block_header   (i_block_header),
        .i_end_of_image   (i_end_of_image),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frag_offset    (o_frag_offset),
        .o_frag_size      (o_frag_size),
        .o_frag_is_header (o_frag_is_header),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Offer one block beat, with an occasional idle burst ahead of it
    task automatic send_block(bit used, bit hdr, bit eoi);
        if (!quiet && $urandom_range(5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_block_used   <= used;
        i_block_header <= hdr;
        i_end_of_image <= eoi;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_block(used, hdr, eoi);
    endtask

    // Drop valid and wait until every predicted fragment has arrived
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, logic [CFG_DATA_BITS-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(r, d);
    endtask

    // Reprogram every register while the block is idle
    task automatic set_config(logic [CFG_DATA_BITS-1:0] bs, logic [CFG_DATA_BITS-1:0] gap,
                              logic [CFG_DATA_BITS-1:0] minf, logic [CFG_DATA_BITS-1:0] maxf,
                              logic [CFG_DATA_BITS-1:0] base);
        drain();
        write_reg(REG_BLOCK_SIZE, bs);
        write_reg(REG_GAP_BLOCKS, gap);
        write_reg(REG_MIN_FRAG, minf);
        write_reg(REG_MAX_FRAG, maxf);
        write_reg(REG_BASE_OFFSET, base);
        i_cfg_valid <= 1'b0;
    endtask

    // Stream one image: header-led runs, plain runs, gaps and some noise, end on the last
    task automatic send_image(int len);
        int sent;
        int cnt;
        int kind;
        sent = 0;
        while (sent < len) begin
            kind = $urandom_range(9);
            cnt  = $urandom_range(4, 1);
            for (int k = 0; k < cnt && sent < len; k++) begin
                sent++;
                case (kind)
                    0:       send_block($urandom_range(1), $urandom_range(1),
                                        sent == len || $urandom_range(31) == 0);
                    1, 2, 3: send_block(1'b1, k == 0, sent == len);
                    4, 5, 6: send_block(1'b1, 1'b0, sent == len);
                    default: send_block(1'b0, $urandom_range(1), sent == len);
                endcase
            end
        end
    endtask

    // Check every fragment beat the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_frag({o_frag_offset, o_frag_size, o_frag_is_header, o_last_of_run});
    end

    // Result-side stall: random bursts, one long hold on request, none when quiet
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(16, 1) - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    initial begin
        int idle;
        idle = 0;
        @(posedge i_rst_n);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [2:0] seq [25];
        int         items;
        int         len;
        bit         paused;

        sb = new();
        sb.reset_all();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_block_used   <= 1'b0;
        i_block_header <= 1'b0;
        i_end_of_image <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_BLOCK_SIZE;
        i_cfg_data     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats, {used, header, end}: gap overrun, gap close, header chains,
        // two fragments from one beat, ignored header bit, then drop and limit stop
        seq = '{3'b100, 3'b100, 3'b000, 3'b100, 3'b000, 3'b000, 3'b110, 3'b100,
                3'b110, 3'b111, 3'b001, 3'b101, 3'b010, 3'b111,
                3'b100, 3'b000, 3'b000, 3'b110, 3'b100, 3'b110, 3'b100, 3'b110,
                3'b100, 3'b110, 3'b001};
        for (int i = 0; i < 25; i++) begin
            if (i == 14)
                set_config(512, 0, 1, 1, 0);
            send_block(seq[i][2], seq[i][1], seq[i][0]);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_config(BSIZE_RESET, GAP_RESET, MINF_RESET, MAXF_ALL, BASE_RESET);
                1: set_config(1, 1, 1, MAXF_ALL, BASE_TOP);
                2: set_config(65536, 16'hFFFF, 0, MAXF_ALL,
                              CFG_DATA_BITS'({$urandom, $urandom}));
                3: set_config($urandom_range(4096, 1), 2, 2, 5,
                              CFG_DATA_BITS'({$urandom, $urandom}));
                4: set_config(0, 3, 0, MAXF_ALL, CFG_DATA_BITS'({$urandom, $urandom}));
                5: set_config($urandom_range(4096, 1), $urandom_range(4), 0, 0, 0);
                6: set_config($urandom_range(65536, 1), $urandom_range(3), 16'hFFFF,
                              MAXF_ALL, BASE_TOP);
                default: set_config($urandom_range(65536, 1), $urandom_range(4),
                                    $urandom_range(3),
                                    $urandom_range(1) ? MAXF_ALL
                                        : CFG_DATA_BITS'($urandom_range(8, 1)),
                                    CFG_DATA_BITS'({$urandom, $urandom}));
            endcase
            if (ph == NUM_PHASES - 1)
                quiet = 1'b1;
            // hold the result side off while blocks keep coming
            if (ph == 0)
                hold_req = 1'b1;
            items  = 0;
            paused = 1'b0;
            while (items < PHASE_ITEMS) begin
                // pause the block side until every fragment is back
                if (ph == 1 && items >= PHASE_ITEMS / 2 && !paused) begin
                    drain();
                    paused = 1'b1;
                end
                len = $urandom_range(30, 1);
                send_image(len);
                items += len;
            end
        end

        drain();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/brf_pkg.sv
design/brf_cfg.sv
design/brf_queue.sv
design/brf_core.sv
design/block_run_fragmenter.sv
tb/tb.sv
